>>> design/assert_macros.svh
// Assertion macros used by the verification checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked only while reset is released.
`define ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> design/rcss_pkg.sv
// Shared types, control word layout and constants of the sliding cursor sprite core.
package rcss_pkg;

    // Default size of the sprite table.
    localparam int SPRITE_SLOTS_DEF = 64;

    // Width of the microprogram counter.
    localparam int PC_W = 5;

    // Width of the signed geometry registers (limits and edge positions).
    localparam int GEO_W = 11;

    // Box element indexes.
    localparam int BOX_X = 0;
    localparam int BOX_Y = 1;
    localparam int BOX_W = 2;
    localparam int BOX_H = 3;

    typedef logic [PC_W-1:0] pc_t;

    // Input item.
    typedef struct packed {
        logic       cmd;
        logic [7:0] box_x;
        logic [7:0] box_y;
        logic [7:0] box_w;
        logic [7:0] box_h;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic       is_empty;
        logic [7:0] sprite_x;
        logic [7:0] sprite_y;
        logic [7:0] tile;
        logic       last;
    } out_item_t;

    // Datapath operation of one microinstruction.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_TARGET,
        OP_LOAD,
        OP_ADVANCE,
        OP_SETUP,
        OP_VSTART,
        OP_HIDE,
        OP_REVEAL
    } uop_t;

    // Jump condition of one microinstruction.
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_TICK,
        C_GOAL_HIDE,
        C_START_HIDDEN,
        C_STEP_DONE,
        C_F_GE_R,
        C_F_GE_B
    } cond_t;

    // Sprite x position source.
    typedef enum logic [1:0] {
        XS_LEFT,
        XS_RIGHT,
        XS_F
    } xsel_t;

    // Sprite y position source.
    typedef enum logic [1:0] {
        YS_TOP,
        YS_BOTTOM,
        YS_F
    } ysel_t;

    // Rule that decides whether an emitted sprite ends the list.
    typedef enum logic [1:0] {
        LK_NONE,
        LK_CORNER,
        LK_HEDGE,
        LK_VEDGE
    } last_kind_t;

    // One control word of the microprogram.
    typedef struct packed {
        uop_t       op;
        cond_t      cond;
        pc_t        target;
        logic       emit;
        logic       empty;
        logic       f_step;
        xsel_t      xsel;
        ysel_t      ysel;
        logic [3:0] piece;
        last_kind_t lk;
    } ctrl_t;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic goal_hide;
        logic start_hidden;
        logic step_done;
        logic f_ge_r;
        logic f_ge_b;
        logic stall;
    } flags_t;

endpackage

>>> design/rcss_urom.sv
// Microprogram read-only table: one control word per program step.
module rcss_urom (
    input  rcss_pkg::pc_t   pc,
    output rcss_pkg::ctrl_t ctrl
);
    import rcss_pkg::*;

    // Program step addresses.
    localparam pc_t S_FETCH    = 5'd0;
    localparam pc_t S_DISPATCH = 5'd1;
    localparam pc_t S_TARGET   = 5'd2;
    localparam pc_t S_CHKSHOWN = 5'd3;
    localparam pc_t S_LOAD     = 5'd4;
    localparam pc_t S_TICK     = 5'd5;
    localparam pc_t S_ADVANCE  = 5'd6;
    localparam pc_t S_SETUP    = 5'd7;
    localparam pc_t S_TL       = 5'd8;
    localparam pc_t S_TR       = 5'd9;
    localparam pc_t S_BL       = 5'd10;
    localparam pc_t S_BR       = 5'd11;
    localparam pc_t S_HLOOP    = 5'd12;
    localparam pc_t S_HTOP     = 5'd13;
    localparam pc_t S_HBOT     = 5'd14;
    localparam pc_t S_VSTART   = 5'd15;
    localparam pc_t S_VLOOP    = 5'd16;
    localparam pc_t S_VLEFT    = 5'd17;
    localparam pc_t S_VRIGHT   = 5'd18;
    localparam pc_t S_HIDE     = 5'd19;
    localparam pc_t S_REVEAL   = 5'd20;

    // Cursor tile pieces.
    localparam logic [3:0] P_TL     = 4'd0;
    localparam logic [3:0] P_TOP    = 4'd1;
    localparam logic [3:0] P_TR     = 4'd2;
    localparam logic [3:0] P_LEFT   = 4'd3;
    localparam logic [3:0] P_RIGHT  = 4'd5;
    localparam logic [3:0] P_BL     = 4'd6;
    localparam logic [3:0] P_BOTTOM = 4'd7;
    localparam logic [3:0] P_BR     = 4'd8;

    // Table contents, one arm per step.
    always_comb begin
        ctrl        = '0;
        ctrl.op     = OP_NONE;
        ctrl.cond   = C_NEXT;
        ctrl.target = S_FETCH;
        ctrl.xsel   = XS_LEFT;
        ctrl.ysel   = YS_TOP;
        ctrl.lk     = LK_NONE;
        unique case (pc)
            S_FETCH: begin
                ctrl.op     = OP_LATCH;
                ctrl.cond   = C_NO_INPUT;
                ctrl.target = S_FETCH;
            end
            S_DISPATCH: begin
                ctrl.cond   = C_IS_TICK;
                ctrl.target = S_TICK;
            end
            S_TARGET: begin
                ctrl.op     = OP_TARGET;
                ctrl.cond   = C_GOAL_HIDE;
                ctrl.target = S_HIDE;
            end
            S_CHKSHOWN: begin
                ctrl.cond   = C_START_HIDDEN;
                ctrl.target = S_REVEAL;
            end
            S_LOAD: begin
                ctrl.op = OP_LOAD;
            end
            S_TICK: begin
                ctrl.cond   = C_STEP_DONE;
                ctrl.target = S_FETCH;
            end
            S_ADVANCE: begin
                ctrl.op = OP_ADVANCE;
            end
            S_SETUP: begin
                ctrl.op = OP_SETUP;
            end
            S_TL: begin
                ctrl.emit  = 1'b1;
                ctrl.piece = P_TL;
            end
            S_TR: begin
                ctrl.emit  = 1'b1;
                ctrl.xsel  = XS_RIGHT;
                ctrl.piece = P_TR;
            end
            S_BL: begin
                ctrl.emit  = 1'b1;
                ctrl.ysel  = YS_BOTTOM;
                ctrl.piece = P_BL;
            end
            S_BR: begin
                ctrl.emit  = 1'b1;
                ctrl.xsel  = XS_RIGHT;
                ctrl.ysel  = YS_BOTTOM;
                ctrl.piece = P_BR;
                ctrl.lk    = LK_CORNER;
            end
            S_HLOOP: begin
                ctrl.cond   = C_F_GE_R;
                ctrl.target = S_VSTART;
            end
            S_HTOP: begin
                ctrl.emit  = 1'b1;
                ctrl.xsel  = XS_F;
                ctrl.piece = P_TOP;
            end
            S_HBOT: begin
                ctrl.emit   = 1'b1;
                ctrl.f_step = 1'b1;
                ctrl.xsel   = XS_F;
                ctrl.ysel   = YS_BOTTOM;
                ctrl.piece  = P_BOTTOM;
                ctrl.lk     = LK_HEDGE;
                ctrl.cond   = C_ALWAYS;
                ctrl.target = S_HLOOP;
            end
            S_VSTART: begin
                ctrl.op = OP_VSTART;
            end
            S_VLOOP: begin
                ctrl.cond   = C_F_GE_B;
                ctrl.target = S_FETCH;
            end
            S_VLEFT: begin
                ctrl.emit  = 1'b1;
                ctrl.ysel  = YS_F;
                ctrl.piece = P_LEFT;
            end
            S_VRIGHT: begin
                ctrl.emit   = 1'b1;
                ctrl.f_step = 1'b1;
                ctrl.xsel   = XS_RIGHT;
                ctrl.ysel   = YS_F;
                ctrl.piece  = P_RIGHT;
                ctrl.lk     = LK_VEDGE;
                ctrl.cond   = C_ALWAYS;
                ctrl.target = S_VLOOP;
            end
            S_HIDE: begin
                ctrl.op     = OP_HIDE;
                ctrl.emit   = 1'b1;
                ctrl.empty  = 1'b1;
                ctrl.cond   = C_ALWAYS;
                ctrl.target = S_FETCH;
            end
            S_REVEAL: begin
                ctrl.op     = OP_REVEAL;
                ctrl.cond   = C_ALWAYS;
                ctrl.target = S_SETUP;
            end
            default: begin
                ctrl.cond   = C_ALWAYS;
                ctrl.target = S_FETCH;
            end
        endcase
    end

endmodule

>>> design/rcss_seq.sv
// Microprogram sequencer: step counter with conditional jumps.
module rcss_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  rcss_pkg::ctrl_t  ctrl,
    input  rcss_pkg::flags_t flags,
    output rcss_pkg::pc_t    pc
);
    import rcss_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    // Jump condition selected by the current control word.
    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:         take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_INPUT:     take = !flags.in_valid;
            C_IS_TICK:      take = flags.is_tick;
            C_GOAL_HIDE:    take = flags.goal_hide;
            C_START_HIDDEN: take = flags.start_hidden;
            C_STEP_DONE:    take = flags.step_done;
            C_F_GE_R:       take = flags.f_ge_r;
            C_F_GE_B:       take = flags.f_ge_b;
            default:        take = 1'b0;
        endcase
    end

    // The step holds while an emit waits for the output register.
    always_comb begin
        priority if (flags.stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign pc = pc_reg;

endmodule

>>> design/rcss_dpath.sv
// Datapath: box registers, slide accumulators, frame geometry and the output register.
module rcss_dpath #(
    parameter int SPRITE_SLOTS = rcss_pkg::SPRITE_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rcss_pkg::ctrl_t     ctrl,
    output rcss_pkg::flags_t    flags,
    input  logic                s_valid,
    output logic                s_ready,
    input  rcss_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rcss_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import rcss_pkg::*;

    localparam int NW = $clog2(SPRITE_SLOTS + 1);

    logic [7:0]              tile_base_reg, tile_base_next;
    in_item_t                in_reg, in_next;
    logic [3:0][7:0]         goal_reg, goal_next;
    logic [3:0][7:0]         start_reg, start_next;
    logic [3:0][7:0]         shown_reg, shown_next;
    logic [3:0][15:0]        sums_reg, sums_next;
    logic [3:0]              step_reg, step_next;
    logic [7:0]              left_reg, left_next;
    logic [7:0]              top_reg, top_next;
    logic signed [GEO_W-1:0] rlim_reg, rlim_next;
    logic signed [GEO_W-1:0] blim_reg, blim_next;
    logic signed [GEO_W-1:0] f_reg, f_next;
    logic [NW-1:0]           n_reg, n_next;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    stall;
    logic                    room;
    logic                    fire;
    logic                    seq_last;
    logic [7:0]              left_c, top_c;
    logic signed [GEO_W-1:0] h_first, v_first, f_plus8;
    logic [8:0]              diff [4];
    logic [15:0]             sum_c [4];
    logic [7:0]              sx, sy;

    // An emit step waits while the output register still holds an untaken item.
    assign stall   = ctrl.emit && out_valid_reg && !m_ready;
    assign room    = n_reg < NW'(SPRITE_SLOTS);
    assign fire    = ctrl.emit && !stall && (ctrl.empty || room);
    assign s_ready = (ctrl.op == OP_LATCH);

    // Frame geometry helpers.
    assign left_c  = shown_reg[BOX_X] - 8'd3;
    assign top_c   = shown_reg[BOX_Y] - 8'd3;
    assign h_first = $signed({3'b000, left_reg}) + 11'sd8;
    assign v_first = $signed({3'b000, top_reg}) + 11'sd8;
    assign f_plus8 = f_reg + 11'sd8;

    // Slide step: signed difference added into each accumulator.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            diff[i]  = {1'b0, goal_reg[i]} - {1'b0, start_reg[i]};
            sum_c[i] = sums_reg[i] + {{7{diff[i][8]}}, diff[i]};
        end
    end

    // End-of-list decision for the sprite being emitted.
    always_comb begin
        unique case (ctrl.lk)
            LK_NONE:   seq_last = 1'b0;
            LK_CORNER: seq_last = (h_first >= rlim_reg) && (v_first >= blim_reg);
            LK_HEDGE:  seq_last = (f_plus8 >= rlim_reg) && (v_first >= blim_reg);
            LK_VEDGE:  seq_last = (f_plus8 >= blim_reg);
            default:   seq_last = 1'b0;
        endcase
    end

    // Sprite position selection.
    always_comb begin
        unique case (ctrl.xsel)
            XS_LEFT:  sx = left_reg;
            XS_RIGHT: sx = rlim_reg[7:0];
            XS_F:     sx = f_reg[7:0];
            default:  sx = left_reg;
        endcase
        unique case (ctrl.ysel)
            YS_TOP:    sy = top_reg;
            YS_BOTTOM: sy = blim_reg[7:0];
            YS_F:      sy = f_reg[7:0];
            default:   sy = top_reg;
        endcase
    end

    // Box, accumulator and geometry updates driven by the control word.
    always_comb begin
        in_next    = in_reg;
        goal_next  = goal_reg;
        start_next = start_reg;
        shown_next = shown_reg;
        sums_next  = sums_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        top_next   = top_reg;
        rlim_next  = rlim_reg;
        blim_next  = blim_reg;
        f_next     = f_reg;
        n_next     = n_reg;
        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_LATCH: begin
                if (s_valid) begin
                    in_next = s_data;
                end
            end
            OP_TARGET: begin
                start_next       = shown_reg;
                goal_next[BOX_X] = in_reg.box_x;
                goal_next[BOX_Y] = in_reg.box_y;
                goal_next[BOX_W] = in_reg.box_w;
                goal_next[BOX_H] = in_reg.box_h;
            end
            OP_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                    sums_next[i] = {5'b00000, start_reg[i], 3'b000};
                end
                step_next = 4'd0;
            end
            OP_ADVANCE: begin
                for (int i = 0; i < 4; i++) begin
                    sums_next[i]  = sum_c[i];
                    shown_next[i] = sum_c[i][10:3];
                end
                step_next = step_reg + 4'd1;
            end
            OP_SETUP: begin
                left_next = left_c;
                top_next  = top_c;
                rlim_next = $signed({3'b000, left_c} + {3'b000, shown_reg[BOX_W]} - 11'd2);
                blim_next = $signed({3'b000, top_c} + {3'b000, shown_reg[BOX_H]} - 11'd2);
                f_next    = $signed({3'b000, left_c}) + 11'sd8;
                n_next    = '0;
            end
            OP_VSTART: begin
                f_next = v_first;
            end
            OP_HIDE: begin
                if (!stall) begin
                    shown_next[BOX_W] = 8'd0;
                    step_next         = 4'd8;
                end
            end
            OP_REVEAL: begin
                shown_next = goal_reg;
                step_next  = 4'd8;
            end
            default: begin
            end
        endcase
        // Emit-side bookkeeping: slot count and edge position step.
        if (fire && !ctrl.empty) begin
            n_next = n_reg + 1'b1;
        end
        if (ctrl.emit && !stall && ctrl.f_step) begin
            f_next = f_plus8;
        end
    end

    // Output register: loaded by an emit that has a free slot or is empty, cleared when the item is taken.
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (fire) begin
            out_valid_next = 1'b1;
            if (ctrl.empty) begin
                out_next          = '0;
                out_next.is_empty = 1'b1;
            end else begin
                out_next.is_empty = 1'b0;
                out_next.sprite_x = sx;
                out_next.sprite_y = sy;
                out_next.tile     = tile_base_reg + {4'b0000, ctrl.piece};
                out_next.last     = seq_last || (n_reg == NW'(SPRITE_SLOTS - 1));
            end
        end
    end

    // Configuration register.
    assign tile_base_next = cfg_we ? cfg_wdata : tile_base_reg;

    // Architectural state and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_base_reg <= '0;
            goal_reg      <= '0;
            start_reg     <= '0;
            shown_reg     <= '0;
            sums_reg      <= '0;
            step_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            tile_base_reg <= tile_base_next;
            goal_reg      <= goal_next;
            start_reg     <= start_next;
            shown_reg     <= shown_next;
            sums_reg      <= sums_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers that need no reset.
    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        left_reg <= left_next;
        top_reg  <= top_next;
        rlim_reg <= rlim_next;
        blim_reg <= blim_next;
        f_reg    <= f_next;
        out_reg  <= out_next;
    end

    // Status back to the sequencer.
    always_comb begin
        flags.in_valid     = s_valid;
        flags.is_tick      = !in_reg.cmd;
        flags.goal_hide    = (in_reg.box_w == 8'd0);
        flags.start_hidden = (start_reg[BOX_W] == 8'd0);
        flags.step_done    = step_reg[3];
        flags.f_ge_r       = (f_reg >= rlim_reg);
        flags.f_ge_b       = (f_reg >= blim_reg);
        flags.stall        = stall;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> design/rect_cursor_slide_sprites_core.sv
// A tick that draws runs the advance, setup, corner and edge steps before it returns to the fetch step;
// a slide target adds the target, check and load steps, and a reveal its own step before the setup.
// A stalled output register holds the microprogram at its emit step until the item is taken.
// Throughput: one item at a time; the next is taken at the fetch step after the last sprite.
// Reset (aresetn, synchronous, active low) clears the boxes, accumulators, step count,
// tile base, output valid and the microprogram counter.
module rect_cursor_slide_sprites_core #(
    parameter int SPRITE_SLOTS = rcss_pkg::SPRITE_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rcss_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rcss_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import rcss_pkg::*;

    pc_t    pc;
    ctrl_t  ctrl;
    flags_t flags;

    // Step counter and jump logic.
    rcss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .flags   (flags),
        .pc      (pc)
    );

    // Control store.
    rcss_urom u_urom (
        .pc   (pc),
        .ctrl (ctrl)
    );

    // Datapath driven by the control word.
    rcss_dpath #(
        .SPRITE_SLOTS (SPRITE_SLOTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .flags     (flags),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> design/rcss_checker.sv
// Port-level assertion checker for the sliding cursor sprite core, with its bind.
`include "assert_macros.svh"

module rcss_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rcss_pkg::out_item_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    import rcss_pkg::*;

    // A result item that waits keeps its value.
    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty

    // The hidden-cursor item carries no sprite and does not close a list.
    property p_empty_clean;
        m_valid && m_data.is_empty |-> m_data.sprite_x == 8'd0 && m_data.sprite_y == 8'd0
            && m_data.tile == 8'd0 && !m_data.last;
    endproperty

    // One item at a time: acceptance drops ready in the following cycle.
    property p_one_item;
        s_valid && s_ready |=> !s_ready;
    endproperty

    `ASSERT_ON(a_out_hold, aclk, aresetn, p_out_hold, "result item changed while stalled")

    `ASSERT_ON(a_empty_clean, aclk, aresetn, p_empty_clean, "empty item has nonzero fields")

    `ASSERT_ON(a_one_item, aclk, aresetn, p_one_item, "second item accepted back to back")

    // Reset leaves no result item pending.
    `ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind rect_cursor_slide_sprites_core rcss_checker u_rcss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

>>> tb/sprite_list_check_pkg.sv
// Predictor and scoreboard for the sprite lists of the sliding cursor core.
package sprite_list_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import rcss_pkg::*;

    class sprite_list_checker;

        // Cursor state as the block should hold it, order x, y, w, h.
        logic [7:0]  tile_base;
        logic [7:0]  goal_box [4];
        logic [7:0]  start_box [4];
        logic [7:0]  shown_box [4];
        logic [15:0] slide_sums [4];
        logic [3:0]  step_count;

        // Sprite items still to come, oldest first.
        out_item_t   sprite_queue [$];
        int          list_len;
        int          mismatches;
        int          sprites_checked;

        function new();
            tile_base = 8'd0;
            for (int i = 0; i < 4; i++) begin
                goal_box[i]   = 8'd0;
                start_box[i]  = 8'd0;
                shown_box[i]  = 8'd0;
                slide_sums[i] = 16'd0;
            end
            step_count      = 4'd0;
            list_len        = 0;
            mismatches      = 0;
            sprites_checked = 0;
        endfunction

        function void set_tile_base(logic [7:0] value);
            tile_base = value;
        endfunction

        function int pending();
            return sprite_queue.size();
        endfunction

        // Appends one sprite unless the table is already full.
        function void put_sprite(int sx, int sy, int piece);
            out_item_t s;
            if (list_len >= SPRITE_SLOTS_DEF) begin
                return;
            end
            s.is_empty = 1'b0;
            s.sprite_x = sx[7:0];
            s.sprite_y = sy[7:0];
            s.tile     = tile_base + piece[7:0];
            s.last     = 1'b0;
            sprite_queue.push_back(s);
            list_len++;
        endfunction

        // Builds the sprite list of the shown box: corners, horizontal pairs, vertical pairs.
        function int draw_box();
            int         left;
            int         top;
            int         right_lim;
            int         bottom_lim;
            logic [7:0] left8;
            logic [7:0] top8;
            out_item_t  tail;
            list_len   = 0;
            left8      = shown_box[BOX_X] - 8'd3;
            top8       = shown_box[BOX_Y] - 8'd3;
            left       = int'(left8);
            top        = int'(top8);
            right_lim  = left + int'(shown_box[BOX_W]) - 2;
            bottom_lim = top + int'(shown_box[BOX_H]) - 2;
            put_sprite(left, top, 0);
            put_sprite(right_lim, top, 2);
            put_sprite(left, bottom_lim, 6);
            put_sprite(right_lim, bottom_lim, 8);
            for (int f = left + 8; f < right_lim; f += 8) begin
                put_sprite(f, top, 1);
                put_sprite(f, bottom_lim, 7);
            end
            for (int f = top + 8; f < bottom_lim; f += 8) begin
                put_sprite(left, f, 3);
                put_sprite(right_lim, f, 5);
            end
            // The final entry of the list carries the last flag.
            if (list_len > 0) begin
                tail      = sprite_queue.pop_back();
                tail.last = 1'b1;
                sprite_queue.push_back(tail);
            end
            return list_len;
        endfunction

        // One slide step; nothing happens once eight steps have run.
        function int run_tick();
            int diff;
            if (step_count >= 4'd8) begin
                return 0;
            end
            for (int i = 0; i < 4; i++) begin
                diff          = int'(goal_box[i]) - int'(start_box[i]);
                slide_sums[i] = slide_sums[i] + diff[15:0];
                shown_box[i]  = slide_sums[i][10:3];
            end
            step_count = step_count + 4'd1;
            return draw_box();
        endfunction

        // Notes an accepted input item and returns how many sprite items it causes.
        function int take_command(in_item_t item);
            out_item_t blank;
            if (!item.cmd) begin
                return run_tick();
            end
            for (int i = 0; i < 4; i++) begin
                start_box[i] = shown_box[i];
            end
            goal_box[BOX_X] = item.box_x;
            goal_box[BOX_Y] = item.box_y;
            goal_box[BOX_W] = item.box_w;
            goal_box[BOX_H] = item.box_h;

            // A zero width hides the cursor and clears the list.
            if (goal_box[BOX_W] == 8'd0) begin
                step_count          = 4'd8;
                shown_box[BOX_W]    = 8'd0;
                blank               = '0;
                blank.is_empty      = 1'b1;
                sprite_queue.push_back(blank);
                return 1;
            end

            // A hidden cursor jumps straight to the goal.
            if (start_box[BOX_W] == 8'd0) begin
                step_count = 4'd8;
                for (int i = 0; i < 4; i++) begin
                    shown_box[i] = goal_box[i];
                end
                return draw_box();
            end

            // Otherwise the slide starts and its first step runs at once.
            for (int i = 0; i < 4; i++) begin
                slide_sums[i] = {5'd0, start_box[i], 3'd0};
            end
            step_count = 4'd0;
            return run_tick();
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Compares one accepted sprite item with the oldest expected one.
        function void check_sprite(out_item_t got);
            out_item_t want;
            if (sprite_queue.size() == 0) begin
                $error("sprite item with nothing expected: x %0d y %0d tile %0d",
                       got.sprite_x, got.sprite_y, got.tile);
                mismatches++;
                return;
            end
            want = sprite_queue.pop_front();
            sprites_checked++;
            compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
            compare_field("sprite_x", want.sprite_x, got.sprite_x);
            compare_field("sprite_y", want.sprite_y, got.sprite_y);
            compare_field("tile", want.tile, got.tile);
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction

    endclass

endpackage

>>> tb/tb_rect_cursor_slide_sprites_core.sv
// Testbench of the sliding cursor sprite core: directed and random commands against a predictor.
module tb_rect_cursor_slide_sprites_core;

    timeunit 1ns;
    timeprecision 1ps;

    import rcss_pkg::*;
    import sprite_list_check_pkg::*;

    // Settle time after the last sprite, longer than the slowest frame walk.
    localparam int IDLE_GAP        = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 80;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;
    int targets_sent   = 0;
    int ticks_sent     = 0;

    sprite_list_checker board;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rect_cursor_slide_sprites_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // The receiver stalls at random by the current percentage.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every accepted sprite item goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_sprite(m_data);
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rect_cursor_slide_sprites_core failed");
            $finish;
        end
    end

    // Offers one command item, after a random idle time, and waits for its acceptance.
    task automatic send_cmd(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] w, input logic [7:0] h);
        in_item_t item;
        item.cmd   = cmd;
        item.box_x = x;
        item.box_y = y;
        item.box_w = w;
        item.box_h = h;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        void'(board.take_command(item));
        if (cmd) begin
            targets_sent++;
        end else begin
            ticks_sent++;
        end
        // Every accepted item counts toward the phase quota.
        items_sent++;
    endtask

    // Holds the sender off until every expected sprite item has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes the tile base once the block has finished all work.
    task automatic write_tile_base(input logic [7:0] value);
        wait_drained();
        repeat (IDLE_GAP) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board.set_tile_base(value);
    endtask

    // Any byte value.
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Box sizes are mostly small, now and then anything in range.
    function automatic logic [7:0] pick_size();
        if ($urandom_range(99) < 8) begin
            return rand_byte();
        end
        return 8'($urandom_range(40, 1));
    endfunction

    // Random slides with random content, plus hides, lone ticks and cut-short slides.
    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [7:0] base);
        int first_item;
        int kind;
        int ticks;
        write_tile_base(base);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        first_item     = items_sent;
        while (items_sent - first_item < ITEMS_PER_PHASE) begin
            if ($urandom_range(24) == 0) begin
                wait_drained();
            end
            kind = $urandom_range(99);
            if (kind < 75) begin
                send_cmd(1'b1, rand_byte(), rand_byte(), pick_size(), pick_size());
                ticks = ($urandom_range(3) == 0) ? $urandom_range(7, 0) : $urandom_range(10, 8);
                repeat (ticks) begin
                    send_cmd(1'b0, rand_byte(), rand_byte(), rand_byte(), rand_byte());
                end
            end else if (kind < 85) begin
                send_cmd(1'b1, rand_byte(), rand_byte(), 8'd0, rand_byte());
            end else begin
                send_cmd(1'b0, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            end
        end
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the tile base at its top so that tile numbers wrap.
        write_tile_base(8'hFF);
        // Ticks after reset draw the zero box eight times, then nothing.
        repeat (9) send_cmd(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Hiding, then revealing a full-size box that overflows the table.
        send_cmd(1'b1, 8'd10, 8'd20, 8'd0, 8'd30);
        send_cmd(1'b1, 8'd0, 8'd0, 8'hFF, 8'hFF);
        send_cmd(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Slide down to the smallest box at the far corner: negative differences.
        send_cmd(1'b1, 8'hFF, 8'hFF, 8'd1, 8'd1);
        send_cmd(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Slide up to a mid-size box, run it out, then one tick past the end.
        send_cmd(1'b1, 8'd128, 8'd64, 8'd40, 8'd24);
        repeat (8) send_cmd(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Hide with all other fields high, then reveal with zero height.
        send_cmd(1'b1, 8'hFF, 8'hFF, 8'd0, 8'hFF);
        send_cmd(1'b1, 8'd3, 8'd3, 8'd1, 8'd0);

        // Random part: no idling, busy sender gaps, receiver stalls, both.
        run_phase(0, 0, 8'h00);
        run_phase(79, 0, rand_byte());
        run_phase(0, 79, 8'hF8);
        run_phase(29, 29, rand_byte());

        wait_drained();
        repeat (IDLE_GAP) @(posedge aclk);

        $display("Checked %0d sprite items from %0d target and %0d tick commands,",
                 board.sprites_checked, targets_sent, ticks_sent);
        $display("over several tile bases and with both channels idle, stalled and busy.");
        if (board.mismatches == 0) begin
            $display("tb_rect_cursor_slide_sprites_core passed");
        end else begin
            $display("tb_rect_cursor_slide_sprites_core failed");
        end
        $finish;
    end

endmodule
